@@ rtl/core/tmm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the temporal min/max/mean accumulator.
// No dependencies.
package tmm_pkg;

    localparam int IDX_W       = 16;
    localparam int STORE_DEPTH = 65536;
    localparam int PIXEL_COUNT = 65536;
    localparam logic [IDX_W:0] PIXEL_LIMIT = (IDX_W + 1)'(PIXEL_COUNT);
    localparam logic [15:0] MAX_FRAMES = 16'd65535;
    localparam logic [23:0] SUM_MAX    = 24'hFFFFFF;
    localparam logic [7:0]  PIX_MAX    = 8'd255;
    localparam int DIV_W   = 40;   // magnitude of sum * mean weight
    localparam int STEP_W  = 6;    // counts DIV_W division steps
    localparam int FRAC_W  = 12;   // Q4.12 weights

    localparam logic signed [15:0] MIN_WEIGHT_RST  = 16'sd0;
    localparam logic signed [15:0] MAX_WEIGHT_RST  = 16'sd0;
    localparam logic signed [15:0] MEAN_WEIGHT_RST = 16'sd4096;

    typedef enum logic [1:0] {
        REQ_ACC   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        REG_MIN_WEIGHT  = 2'd0,
        REG_MAX_WEIGHT  = 2'd1,
        REG_MEAN_WEIGHT = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture transaction, read the stores
        logic exec;       // update stores/count, form products
        logic div_load;   // take magnitude of the mean product
        logic div_step;   // one restoring-division step
        logic sum;        // blend, clamp
        logic out_load;   // capture result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_read;
        logic read_ok;
        logic div_last;
    } t_status;

endpackage

@@ rtl/core/tmm_if.sv @@
`timescale 1ns / 1ps
// Request and result channel interfaces (valid/ready).
// Depends on tmm_pkg.
interface tmm_req_if import tmm_pkg::*;;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] pixel_index;
    logic [7:0]  sample;
    logic        last_of_frame;

    modport source (output valid, req_type, pixel_index, sample, last_of_frame,
                    input ready);
    modport sink   (input valid, req_type, pixel_index, sample, last_of_frame,
                    output ready);
endinterface

interface tmm_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_value;
    logic        empty_res;
    logic [15:0] frames_held;

    modport source (output valid, pixel_value, empty_res, frames_held, input ready);
    modport sink   (input valid, pixel_value, empty_res, frames_held, output ready);
endinterface

@@ rtl/core/tmm_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing FSM of the accumulator.
// Depends on tmm_pkg.
module tmm_ctrl import tmm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_DLOAD  = 6'b000100,
        S_DIV    = 6'b001000,
        S_SUM    = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.is_read && i_status.read_ok) n_state = S_DLOAD;
                else                                      n_state = S_FINISH;
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load)   r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

endmodule

@@ rtl/core/tmm_datapath.sv @@
`timescale 1ns / 1ps
// Pixel stores, frame counter, blend arithmetic and result register.
// Depends on tmm_pkg.
module tmm_datapath import tmm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [1:0]         i_req_type,
    input  logic [IDX_W-1:0]   i_pixel_index,
    input  logic [7:0]         i_sample,
    input  logic               i_last_of_frame,
    input  logic signed [15:0] i_min_weight,
    input  logic signed [15:0] i_max_weight,
    input  logic signed [15:0] i_mean_weight,
    output logic [7:0]         o_pixel_value,
    output logic               o_empty_res,
    output logic [15:0]        o_frames_held
);

    logic [7:0]  min_mem [STORE_DEPTH];
    logic [7:0]  max_mem [STORE_DEPTH];
    logic [23:0] sum_mem [STORE_DEPTH];

    t_req               r_req;
    logic [IDX_W-1:0]   r_idx;
    logic [7:0]         r_smp;
    logic               r_last;
    logic [15:0]        r_count;
    logic [7:0]         r_min_rd, r_max_rd;
    logic [23:0]        r_sum_rd;
    logic signed [24:0] r_p_min, r_p_max;
    logic signed [40:0] r_p_mean;
    logic               r_neg;
    logic [DIV_W-1:0]   r_dvd;     // dividend, shifts into quotient
    logic [15:0]        r_rem;
    logic [STEP_W-1:0]  r_step;
    logic [7:0]         r_pix;
    logic [7:0]         r_out_pix;
    logic               r_out_empty;
    logic [15:0]        r_out_frames;

    logic               in_range;
    logic               mem_wr;
    logic [7:0]         new_min, new_max;
    logic [24:0]        sum_ext;
    logic [23:0]        new_sum;
    logic [16:0]        trial;
    logic               q_bit;
    logic [40:0]        mean_mag;
    logic signed [40:0] quo_s;
    logic signed [42:0] total;

    assign in_range = ({1'b0, r_idx} < PIXEL_LIMIT);
    assign mem_wr   = i_cmd.exec && (r_req == REQ_ACC) && in_range;

    always_comb begin
        if (r_count == '0) begin
            new_min = r_smp;
            new_max = r_smp;
            new_sum = {16'd0, r_smp};
        end else begin
            new_min = (r_smp < r_min_rd) ? r_smp : r_min_rd;
            new_max = (r_smp > r_max_rd) ? r_smp : r_max_rd;
            new_sum = (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[23:0];
        end
    end
    assign sum_ext = {1'b0, r_sum_rd} + {17'd0, r_smp};

    // stores: one write and one registered read port each
    always_ff @(posedge i_clk) begin
        if (mem_wr) min_mem[r_idx] <= new_min;
        if (i_cmd.load) r_min_rd <= min_mem[i_pixel_index];
    end
    always_ff @(posedge i_clk) begin
        if (mem_wr) max_mem[r_idx] <= new_max;
        if (i_cmd.load) r_max_rd <= max_mem[i_pixel_index];
    end
    always_ff @(posedge i_clk) begin
        if (mem_wr) sum_mem[r_idx] <= new_sum;
        if (i_cmd.load) r_sum_rd <= sum_mem[i_pixel_index];
    end

    // restoring division step
    assign trial    = {r_rem, r_dvd[DIV_W-1]};
    assign q_bit    = (trial >= {1'b0, r_count});
    assign mean_mag = r_p_mean[40] ? 41'(-r_p_mean) : 41'(r_p_mean);
    assign quo_s    = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
    assign total    = 43'(r_p_min) + 43'(r_p_max) + 43'(quo_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (r_req == REQ_ACC) begin
                if (r_last && r_count != MAX_FRAMES) r_count <= r_count + 16'd1;
            end else if (r_req == REQ_CLEAR) begin
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= t_req'(i_req_type);
            r_idx  <= i_pixel_index;
            r_smp  <= i_sample;
            r_last <= i_last_of_frame;
            r_pix  <= '0;
        end
        if (i_cmd.exec) begin
            r_p_min  <= $signed({1'b0, r_min_rd}) * i_min_weight;
            r_p_max  <= $signed({1'b0, r_max_rd}) * i_max_weight;
            r_p_mean <= $signed({1'b0, r_sum_rd}) * i_mean_weight;
        end
        if (i_cmd.div_load) begin
            r_dvd  <= mean_mag[DIV_W-1:0];
            r_rem  <= '0;
            r_neg  <= r_p_mean[40];
            r_step <= STEP_W'(DIV_W - 1);
        end
        if (i_cmd.div_step) begin
            r_rem  <= q_bit ? 16'(trial - {1'b0, r_count}) : trial[15:0];
            r_dvd  <= {r_dvd[DIV_W-2:0], q_bit};
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.sum) begin
            if (total[42])                                  r_pix <= '0;
            else if (total[41:FRAC_W] > 30'(PIX_MAX))       r_pix <= PIX_MAX;
            else                                            r_pix <= total[FRAC_W+7:FRAC_W];
        end
        if (i_cmd.out_load) begin
            r_out_pix    <= r_pix;
            r_out_empty  <= (r_count == '0);
            r_out_frames <= r_count;
        end
    end

    assign o_status.is_read  = (r_req == REQ_READ);
    assign o_status.read_ok  = (r_count != '0) && in_range;
    assign o_status.div_last = (r_step == '0);

    assign o_pixel_value = r_out_pix;
    assign o_empty_res   = r_out_empty;
    assign o_frames_held = r_out_frames;

endmodule

@@ rtl/core/temporal_min_max_mean_accumulator.sv @@
`timescale 1ns / 1ps
// Temporal min/max/mean accumulator: top level, APB weight registers.
// Depends on tmm_pkg, tmm_if, tmm_ctrl, tmm_datapath.
//
// One transaction at a time. Accumulate, clear and unused request codes go
// through accept, store update and result load. A read of a held pixel goes
// through accept, product, divider load, divider steps, blend and result load;
// the mean term sum*mean_weight/count goes through a 40-bit restoring divider
// that retires one quotient bit per cycle. A read while no frame is held, or
// of an index past the frame, goes straight from product to result load.
// The result sits in an output register, so a new request is accepted while
// the previous result still waits. Stores hold arbitrary data after reset
// until each pixel is written in a first frame; frames_held resets to zero.
// Weights are written over APB at 0x0 (min), 0x4 (max), 0x8 (mean), signed
// Q4.12, only while the block is idle: a user rule the block does not enforce.
module temporal_min_max_mean_accumulator import tmm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmm_req_if.sink     i_req,
    tmm_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [15:0] r_min_weight, r_max_weight, r_mean_weight;
    logic               cfg_wr;
    t_reg_idx           reg_idx;
    t_cmd               cmd;
    t_status            status;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_weight  <= MIN_WEIGHT_RST;
            r_max_weight  <= MAX_WEIGHT_RST;
            r_mean_weight <= MEAN_WEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MIN_WEIGHT:  r_min_weight  <= pwdata[15:0];
                REG_MAX_WEIGHT:  r_max_weight  <= pwdata[15:0];
                REG_MEAN_WEIGHT: r_mean_weight <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MIN_WEIGHT:  prdata = 32'(r_min_weight);
            REG_MAX_WEIGHT:  prdata = 32'(r_max_weight);
            REG_MEAN_WEIGHT: prdata = 32'(r_mean_weight);
            default:         prdata = '0;
        endcase
    end

    tmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tmm_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_req_type      (i_req.req_type),
        .i_pixel_index   (i_req.pixel_index),
        .i_sample        (i_req.sample),
        .i_last_of_frame (i_req.last_of_frame),
        .i_min_weight    (r_min_weight),
        .i_max_weight    (r_max_weight),
        .i_mean_weight   (r_mean_weight),
        .o_pixel_value   (o_res.pixel_value),
        .o_empty_res     (o_res.empty_res),
        .o_frames_held   (o_res.frames_held)
    );

endmodule

@@ rtl/core/tmm_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the accumulator, bound to the top level.
// Depends on temporal_min_max_mean_accumulator.
module tmm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_pixel_value,
    input logic        i_empty_res,
    input logic [15:0] i_frames_held
);

    a_rst_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while one is in flight");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_empty_res == (i_frames_held == 16'd0)))
        else $error("empty flag disagrees with frame count");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_empty_res |-> i_pixel_value == 8'd0)
        else $error("pixel value while empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_frames_held))
        else $error("stalled result dropped or changed");

endmodule

bind temporal_min_max_mean_accumulator tmm_checker u_tmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_pixel_value (o_res.pixel_value),
    .i_empty_res   (o_res.empty_res),
    .i_frames_held (o_res.frames_held)
);
